[sv/ycf_pkg.sv]
package ycf_pkg;

  localparam int ANG_PI     = 25736;
  localparam int ANG_TWO_PI = 51472;

  localparam int CFG_AW = 5;
  localparam int CFG_DW = 32;

  localparam logic [2:0] REG_PASS_THROUGH = 3'd0;
  localparam logic [2:0] REG_GAIN_STILL   = 3'd1;
  localparam logic [2:0] REG_GAIN_MOVING  = 3'd2;
  localparam logic [2:0] REG_STILL_RATE   = 3'd3;
  localparam logic [2:0] REG_SNAP_LIMIT   = 3'd4;
  localparam logic [2:0] REG_RECHECK      = 3'd5;
  localparam logic [2:0] REG_HOLD_TIME    = 3'd6;

  localparam logic [15:0] RST_GAIN_STILL   = 16'd655;
  localparam logic [15:0] RST_GAIN_MOVING  = 16'd328;
  localparam logic [14:0] RST_STILL_RATE   = 15'd410;
  localparam logic [14:0] RST_SNAP_LIMIT   = 15'd2859;
  localparam logic [14:0] RST_RECHECK      = 15'd715;
  localparam logic [31:0] RST_HOLD_TIME    = 32'd1000000;

  typedef struct packed {
    logic        pass_through_mode;
    logic [15:0] gain_still;
    logic [15:0] gain_moving;
    logic [14:0] still_rate_limit;
    logic [14:0] snap_limit;
    logic [14:0] recheck_limit;
    logic [31:0] hold_time_us;
  } cfg_t;

  typedef struct packed {
    logic signed [15:0] radar_heading;
    logic signed [15:0] gyro_yaw;
    logic signed [15:0] gyro_rate;
    logic        [31:0] now_us;
  } in_word_t;

  typedef struct packed {
    logic               write_yaw;
    logic signed [15:0] new_yaw;
  } out_word_t;

endpackage

[sv/ycf_regs.sv]
module ycf_regs (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [ycf_pkg::CFG_AW-1:0] paddr,
  input  logic [ycf_pkg::CFG_DW-1:0] pwdata,
  output logic [ycf_pkg::CFG_DW-1:0] prdata,
  output logic                       pready,
  output ycf_pkg::cfg_t              cfg
);
  import ycf_pkg::*;

  logic [2:0] reg_idx;
  logic       wr_en;

  assign reg_idx = paddr[CFG_AW-1:2];
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.pass_through_mode <= 1'b0;
      cfg.gain_still        <= RST_GAIN_STILL;
      cfg.gain_moving       <= RST_GAIN_MOVING;
      cfg.still_rate_limit  <= RST_STILL_RATE;
      cfg.snap_limit        <= RST_SNAP_LIMIT;
      cfg.recheck_limit     <= RST_RECHECK;
      cfg.hold_time_us      <= RST_HOLD_TIME;
    end else if (wr_en) begin
      case (reg_idx)
        REG_PASS_THROUGH: cfg.pass_through_mode <= pwdata[0];
        REG_GAIN_STILL:   cfg.gain_still        <= pwdata[15:0];
        REG_GAIN_MOVING:  cfg.gain_moving       <= pwdata[15:0];
        REG_STILL_RATE:   cfg.still_rate_limit  <= pwdata[14:0];
        REG_SNAP_LIMIT:   cfg.snap_limit        <= pwdata[14:0];
        REG_RECHECK:      cfg.recheck_limit     <= pwdata[14:0];
        REG_HOLD_TIME:    cfg.hold_time_us      <= pwdata[31:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_PASS_THROUGH: prdata = {31'd0, cfg.pass_through_mode};
      REG_GAIN_STILL:   prdata = {16'd0, cfg.gain_still};
      REG_GAIN_MOVING:  prdata = {16'd0, cfg.gain_moving};
      REG_STILL_RATE:   prdata = {17'd0, cfg.still_rate_limit};
      REG_SNAP_LIMIT:   prdata = {17'd0, cfg.snap_limit};
      REG_RECHECK:      prdata = {17'd0, cfg.recheck_limit};
      REG_HOLD_TIME:    prdata = cfg.hold_time_us;
      default:          prdata = '0;
    endcase
  end

endmodule

[sv/ycf_core.sv]
module ycf_core (
  input  logic               clk,
  input  logic               rst,
  input  ycf_pkg::cfg_t      cfg,
  input  logic               in_valid,
  output logic               in_stall,
  input  ycf_pkg::in_word_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output ycf_pkg::out_word_t out_data
);
  import ycf_pkg::*;

  localparam logic signed [17:0] PI_Q     = 18'(ANG_PI);
  localparam logic signed [17:0] TWO_PI_Q = 18'(ANG_TWO_PI);

  function automatic logic signed [17:0] wrap_once(input logic signed [17:0] a);
    logic signed [17:0] r;
    r = a;
    if (a > PI_Q) begin
      r = a - TWO_PI_Q;
    end else if (a < -PI_Q) begin
      r = a + TWO_PI_Q;
    end
    return r;
  endfunction

  in_word_t in_q;
  logic     in_full;
  logic     en;
  logic     proc;

  logic              started, started_next;
  logic [15:0]       prev_radar, prev_radar_next;
  logic              recheck_pending, recheck_pending_next;
  logic [31:0]       recheck_start_us, recheck_start_us_next;

  logic signed [17:0] radar_x, gyro_x, err, err_abs, delta, yaw_sum, yaw_wrap;
  logic signed [16:0] rate_x, rate_abs;
  logic [14:0]        mag;
  logic [15:0]        gain;
  logic [30:0]        prod;
  logic               still;
  logic               arm;
  logic [31:0]        start_eff;
  logic [31:0]        elapsed;
  out_word_t          result;

  assign en       = !out_valid || !out_stall;
  assign proc     = in_full && en;
  assign in_stall = in_full && !en;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_valid && !in_stall) begin
      in_full <= 1'b1;
    end else if (proc) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_q <= in_data;
    end
  end

  always_comb begin
    radar_x  = 18'(in_q.radar_heading);
    gyro_x   = 18'(in_q.gyro_yaw);
    rate_x   = 17'(in_q.gyro_rate);
    rate_abs = (rate_x < 0) ? -rate_x : rate_x;
    still    = rate_abs < $signed({2'b00, cfg.still_rate_limit});
    gain     = still ? cfg.gain_still : cfg.gain_moving;
    err      = wrap_once(radar_x - gyro_x);
    err_abs  = (err < 0) ? -err : err;
    mag      = err_abs[14:0];
    prod     = 31'(gain) * 31'(mag);
    delta    = (err < 0) ? -$signed({3'b000, prod[30:16]}) : $signed({3'b000, prod[30:16]});
    yaw_sum  = gyro_x + delta;
    yaw_wrap = wrap_once(yaw_sum);
    arm       = !recheck_pending && (mag > cfg.recheck_limit) && still;
    start_eff = arm ? in_q.now_us : recheck_start_us;
    elapsed   = in_q.now_us - start_eff;
  end

  always_comb begin
    started_next          = started;
    prev_radar_next       = prev_radar;
    recheck_pending_next  = recheck_pending;
    recheck_start_us_next = recheck_start_us;
    result.write_yaw      = 1'b0;
    result.new_yaw        = '0;
    if (cfg.pass_through_mode) begin
      result.write_yaw = 1'b1;
      result.new_yaw   = in_q.radar_heading;
      started_next     = 1'b0;
    end else if (!started) begin
      result.write_yaw = 1'b1;
      result.new_yaw   = in_q.radar_heading;
      started_next     = 1'b1;
    end else if (in_q.radar_heading != prev_radar) begin
      prev_radar_next  = in_q.radar_heading;
      result.write_yaw = 1'b1;
      result.new_yaw   = yaw_wrap[15:0];
      if (mag > cfg.snap_limit) begin
        result.new_yaw = in_q.radar_heading;
      end
      if (arm) begin
        recheck_pending_next  = 1'b1;
        recheck_start_us_next = in_q.now_us;
      end
      if ((recheck_pending || arm) && (elapsed > cfg.hold_time_us)) begin
        if ((mag > cfg.recheck_limit) && still) begin
          result.new_yaw = in_q.radar_heading;
        end
        recheck_pending_next = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      started          <= 1'b0;
      prev_radar       <= '0;
      recheck_pending  <= 1'b0;
      recheck_start_us <= '0;
    end else if (proc) begin
      started          <= started_next;
      prev_radar       <= prev_radar_next;
      recheck_pending  <= recheck_pending_next;
      recheck_start_us <= recheck_start_us_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_full;
    end
  end

  always_ff @(posedge clk) begin
    if (proc) begin
      out_data <= result;
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (in_full && out_valid && out_stall))
    else $error("input stalled without a blocked result");

  assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(proc))
    else $error("result appeared without a processed word");

  assert property (@(posedge clk) disable iff (rst)
    (proc && cfg.pass_through_mode) |=> !started)
    else $error("pass-through left the filter started");

  assert property (@(posedge clk) disable iff (rst)
    $rose(recheck_pending) |-> ($past(proc) && $past(arm)))
    else $error("hold timer armed outside a fused word");

  assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_data.write_yaw) |-> (out_data.new_yaw == 16'sd0))
    else $error("heading nonzero on a result without write");

endmodule

[sv/yaw_complementary_fusion.sv]
// Heading correction by complementary fusion of a radar yaw into a gyro yaw. Each input word
// carries the radar yaw, gyro yaw, gyro rate and a microsecond timestamp, and yields one result
// word that says whether to overwrite the gyro yaw and with which heading. The block takes one
// word per cycle unless the output stalls, holding each word in the input register and its result
// word in the result register; the single compute path between them runs through the gain multiplier
// and the heading wrap into the result register, with the filter state updated as each word leaves
// the input register. Configuration registers sit on an APB-style port at byte addresses 4*i and
// are to be written while no word is in flight.
module yaw_complementary_fusion (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [ycf_pkg::CFG_AW-1:0] paddr,
  input  logic [ycf_pkg::CFG_DW-1:0] pwdata,
  output logic [ycf_pkg::CFG_DW-1:0] prdata,
  output logic                       pready,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  ycf_pkg::in_word_t          in_data,
  output logic                       out_valid,
  input  logic                       out_stall,
  output ycf_pkg::out_word_t         out_data
);
  import ycf_pkg::*;

  cfg_t cfg;

  ycf_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  ycf_core u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

[test/testbench.sv]
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import ycf_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [CFG_AW-1:0] paddr = '0;
  logic [CFG_DW-1:0] pwdata = '0;
  logic [CFG_DW-1:0] prdata;
  logic pready;

  logic in_valid = 1'b0;
  logic in_stall;
  in_word_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_word_t out_data;

  yaw_complementary_fusion uut (
    .clk(clk),
    .rst(rst),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data)
  );

  always #2 clk = ~clk;

  // Register copy and filter state of the heading predictor.
  cfg_t shadow = '{
    pass_through_mode: 1'b0,
    gain_still: RST_GAIN_STILL,
    gain_moving: RST_GAIN_MOVING,
    still_rate_limit: RST_STILL_RATE,
    snap_limit: RST_SNAP_LIMIT,
    recheck_limit: RST_RECHECK,
    hold_time_us: RST_HOLD_TIME
  };
  logic fuse_started = 1'b0;
  logic [15:0] last_radar_seen = '0;
  logic snap_pending = 1'b0;
  logic [31:0] pending_since_us = '0;

  out_word_t heading_q[$];
  out_word_t due_word;
  int fail_count = 0;

  logic sender_idles = 1'b1;
  logic sink_stalls = 1'b1;
  logic [31:0] stamp_us = '0;
  int tick_span = 5000;
  logic signed [15:0] last_radar = '0;

  function automatic int wrap_angle(input int a);
    if (a > ANG_PI) return a - ANG_TWO_PI;
    if (a < -ANG_PI) return a + ANG_TWO_PI;
    return a;
  endfunction

  function automatic out_word_t predict_heading(input in_word_t w);
    out_word_t r;
    int radar;
    int gyro;
    int rate;
    int err;
    int mag;
    int delta;
    int yaw;
    logic still;
    logic [15:0] gain;
    logic [31:0] elapsed;
    longint prod;
    radar = $signed(w.radar_heading);
    gyro = $signed(w.gyro_yaw);
    rate = $signed(w.gyro_rate);
    r = '0;
    if (shadow.pass_through_mode) begin
      r.write_yaw = 1'b1;
      r.new_yaw = w.radar_heading;
      fuse_started = 1'b0;
    end else if (!fuse_started) begin
      r.write_yaw = 1'b1;
      r.new_yaw = w.radar_heading;
      fuse_started = 1'b1;
    end else if (w.radar_heading != last_radar_seen) begin
      last_radar_seen = w.radar_heading;
      if (rate < 0) rate = -rate;
      still = rate < int'(shadow.still_rate_limit);
      gain = still ? shadow.gain_still : shadow.gain_moving;
      err = wrap_angle(radar - gyro);
      mag = (err < 0) ? -err : err;
      prod = longint'(gain) * longint'(mag);
      delta = int'(prod >>> 16);
      if (err < 0) delta = -delta;
      yaw = wrap_angle(gyro + delta);
      if (mag > int'(shadow.snap_limit)) yaw = radar;
      if (!snap_pending && mag > int'(shadow.recheck_limit) && still) begin
        snap_pending = 1'b1;
        pending_since_us = w.now_us;
      end
      elapsed = w.now_us - pending_since_us;
      if (snap_pending && elapsed > shadow.hold_time_us) begin
        if (mag > int'(shadow.recheck_limit) && still) yaw = radar;
        snap_pending = 1'b0;
      end
      r.write_yaw = 1'b1;
      r.new_yaw = 16'(yaw);
    end
    return r;
  endfunction

  function automatic in_word_t make_word(input int focus);
    in_word_t w;
    int radar;
    int err;
    int gyro;
    int rate;
    int lim;
    int sgn;
    int rsgn;
    sgn = $urandom_range(1, 0) ? 1 : -1;
    rsgn = $urandom_range(1, 0) ? 1 : -1;
    lim = int'(shadow.still_rate_limit);
    stamp_us = stamp_us + $urandom_range(tick_span, 0);
    if ($urandom_range(99, 0) < 5) begin
      w.radar_heading = 16'($urandom);
      w.gyro_yaw = 16'($urandom);
      w.gyro_rate = 16'($urandom);
      w.now_us = $urandom;
      last_radar = w.radar_heading;
      return w;
    end
    if ($urandom_range(99, 0) < 12) radar = last_radar;
    else radar = int'($urandom_range(ANG_TWO_PI, 0)) - ANG_PI;
    if ($urandom_range(99, 0) < focus) begin
      err = sgn * (int'(shadow.recheck_limit) + 1 + int'($urandom_range(2000, 0)));
      rate = (lim > 0) ? rsgn * int'($urandom_range(lim - 1, 0)) : 0;
    end else begin
      case ($urandom_range(3, 0))
        0: err = int'($urandom_range(1400, 0)) - 700;
        1: err = sgn * (int'(shadow.snap_limit) + int'($urandom_range(2, 0)) - 1);
        2: err = sgn * (int'(shadow.recheck_limit) + int'($urandom_range(2, 0)) - 1);
        default: err = int'($urandom_range(ANG_TWO_PI, 0)) - ANG_PI;
      endcase
      case ($urandom_range(2, 0))
        0: rate = (lim > 0) ? rsgn * int'($urandom_range(lim - 1, 0)) : 0;
        1: rate = rsgn * lim;
        default: rate = int'($urandom_range(65535, 0)) - 32768;
      endcase
    end
    gyro = wrap_angle(radar - err);
    w.radar_heading = 16'(radar);
    w.gyro_yaw = 16'(gyro);
    w.gyro_rate = 16'(rate);
    w.now_us = stamp_us;
    last_radar = w.radar_heading;
    return w;
  endfunction

  function automatic in_word_t heading_word(input int radar, input int gyro, input int rate,
                                            input logic [31:0] now);
    in_word_t w;
    w.radar_heading = 16'(radar);
    w.gyro_yaw = 16'(gyro);
    w.gyro_rate = 16'(rate);
    w.now_us = now;
    return w;
  endfunction

  task automatic send_word(input in_word_t w);
    while (sender_idles && $urandom_range(99, 0) < 26) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= w;
    do @(posedge clk); while (in_stall);
    heading_q.push_back(predict_heading(w));
  endtask

  task automatic send_random(input int count, input int focus);
    repeat (count) send_word(make_word(focus));
  endtask

  task automatic quiesce();
    in_valid <= 1'b0;
    while (heading_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_PASS_THROUGH: shadow.pass_through_mode = value[0];
      REG_GAIN_STILL: shadow.gain_still = value[15:0];
      REG_GAIN_MOVING: shadow.gain_moving = value[15:0];
      REG_STILL_RATE: shadow.still_rate_limit = value[14:0];
      REG_SNAP_LIMIT: shadow.snap_limit = value[14:0];
      REG_RECHECK: shadow.recheck_limit = value[14:0];
      REG_HOLD_TIME: shadow.hold_time_us = value;
      default: ;
    endcase
  endtask

  // With garble set, the unused upper data bits carry random values.
  task automatic apply_settings(input logic pass, input logic [15:0] gs, input logic [15:0] gm,
                                input logic [14:0] sr, input logic [14:0] sn,
                                input logic [14:0] rc, input logic [31:0] hold,
                                input logic garble);
    quiesce();
    write_reg(REG_PASS_THROUGH, garble ? {31'($urandom), pass} : 32'(pass));
    write_reg(REG_GAIN_STILL, garble ? {16'($urandom), gs} : 32'(gs));
    write_reg(REG_GAIN_MOVING, garble ? {16'($urandom), gm} : 32'(gm));
    write_reg(REG_STILL_RATE, garble ? {17'($urandom), sr} : 32'(sr));
    write_reg(REG_SNAP_LIMIT, garble ? {17'($urandom), sn} : 32'(sn));
    write_reg(REG_RECHECK, garble ? {17'($urandom), rc} : 32'(rc));
    write_reg(REG_HOLD_TIME, hold);
  endtask

  task automatic note_failure(input string what, input out_word_t want, input out_word_t got);
    fail_count++;
    if (fail_count <= 10)
      $display("%s: expected write=%0b yaw=%0d, got write=%0b yaw=%0d", what,
               want.write_yaw, want.new_yaw, got.write_yaw, got.new_yaw);
  endtask

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (heading_q.size() == 0) begin
        note_failure("result word with nothing expected", '0, out_data);
      end else begin
        due_word = heading_q.pop_front();
        if (out_data.write_yaw !== due_word.write_yaw || out_data.new_yaw !== due_word.new_yaw)
          note_failure("heading mismatch", due_word, out_data);
      end
    end
    out_stall <= sink_stalls && ($urandom_range(99, 0) < 26);
  end

  task automatic test_directed_cases();
    send_word(heading_word(25736, -25736, 32767, 32'd0));
    send_word(heading_word(0, 1234, 0, 32'd10));
    send_word(heading_word(-25736, 25736, -32768, 32'd20));
    send_word(heading_word(-25736, 0, 0, 32'd30));
    send_word(heading_word(25736, -25736, 0, 32'd40));
    send_word(heading_word(20000, -10000, 5000, 32'd50));
    send_word(heading_word(1000, 900, 5000, 32'd60));
    send_word(heading_word(1100, 1000, 0, 32'd70));
    send_word(heading_word(2000, 1000, 100, 32'd1000));
    send_word(heading_word(2100, 1050, -100, 32'd1001000));
    send_word(heading_word(2200, 1100, 0, 32'd1001001));
    send_word(heading_word(-2000, -1000, -409, 32'hFFFF_FF00));
    send_word(heading_word(-2100, -1000, 410, 32'h000F_4200));
    send_word(heading_word(3859, 1000, 20000, 32'h0010_0000));
    send_word(heading_word(3860, 1000, 20000, 32'h0010_0010));
    send_word(heading_word(-32768, 32767, 0, 32'hFFFF_FFFF));
    send_word(heading_word(32767, -32768, -1, 32'd0));
    send_word(heading_word(-1, 1, 1, 32'd5));
    send_word(heading_word(25000, 25736, -32768, 32'd6));
    send_word(heading_word(0, 0, 0, 32'd7));
  endtask

  task automatic test_register_extremes();
    int k;
    for (k = 0; k < 6; k++) begin
      case (k)
        0: apply_settings(1'b0, 16'd0, 16'd0, 15'd0, 15'd25736, 15'd25736, 32'd0, 1'b0);
        1: apply_settings(1'b0, 16'hFFFF, 16'hFFFF, 15'h7FFF, 15'd0, 15'd0, 32'hFFFF_FFFF, 1'b0);
        2: apply_settings(1'b0, 16'hFFFF, 16'd0, RST_STILL_RATE, RST_SNAP_LIMIT, RST_RECHECK,
                          32'd500, 1'b0);
        5: apply_settings(1'b0, RST_GAIN_STILL, RST_GAIN_MOVING, RST_STILL_RATE, RST_SNAP_LIMIT,
                          RST_RECHECK, 32'd3000, 1'b1);
        default: apply_settings(1'b0, 16'($urandom), 16'($urandom),
                                15'($urandom_range(32767, 0)), 15'($urandom_range(25736, 0)),
                                15'($urandom_range(25736, 0)), $urandom_range(20000, 0), 1'b0);
      endcase
      send_random(90, 10);
    end
  endtask

  task automatic test_pass_through();
    apply_settings(1'b1, RST_GAIN_STILL, RST_GAIN_MOVING, RST_STILL_RATE, RST_SNAP_LIMIT,
                   RST_RECHECK, RST_HOLD_TIME, 1'b0);
    send_random(100, 10);
  endtask

  task automatic test_delayed_snap();
    tick_span = 400;
    apply_settings(1'b0, 16'($urandom), 16'($urandom), RST_STILL_RATE, 15'd25736, RST_RECHECK,
                   $urandom_range(3000, 0), 1'b0);
    send_random(100, 70);
    apply_settings(1'b0, RST_GAIN_STILL, RST_GAIN_MOVING, RST_STILL_RATE, RST_SNAP_LIMIT,
                   RST_RECHECK, $urandom_range(1500, 0), 1'b0);
    send_random(100, 70);
    stamp_us = 32'hFFFF_F000;
    apply_settings(1'b0, RST_GAIN_STILL, RST_GAIN_MOVING, 15'd2000, RST_SNAP_LIMIT,
                   RST_RECHECK, 32'd800, 1'b0);
    send_random(100, 70);
    tick_span = 5000;
  endtask

  task automatic test_back_to_back();
    sender_idles = 1'b0;
    sink_stalls = 1'b0;
    send_random(160, 30);
    sender_idles = 1'b1;
    sink_stalls = 1'b1;
  endtask

  task automatic test_pause_until_drained();
    send_random(50, 30);
    quiesce();
    send_random(50, 30);
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    test_directed_cases();
    test_register_extremes();
    test_pass_through();
    test_delayed_snap();
    test_back_to_back();
    test_pause_until_drained();
    quiesce();
    repeat (8) @(posedge clk);
    if (fail_count == 0 && heading_q.size() == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("testbench NOT OK");
    $finish;
  end

endmodule
